/* sv/fbes_pkg.sv */
`default_nettype none

package fbes_pkg;

    // Default geometry of the flash part.
    localparam int unsigned EraseBlockBytesDefault = 65536;
    localparam int unsigned AddressBitsDefault     = 24;

    // Field widths.
    localparam int unsigned FlashAddrW = 24;
    localparam int unsigned ByteCountW = 25;
    localparam int unsigned InternAddrW = 26;
    localparam int unsigned StatusW    = 8;
    localparam int unsigned OpcodeW    = 8;
    localparam int unsigned PhaseW     = 3;

    // Phase codes, also reported as state_code.
    localparam logic [PhaseW-1:0] PhIdle      = 3'd0;
    localparam logic [PhaseW-1:0] PhBlank     = 3'd1;
    localparam logic [PhaseW-1:0] PhErase     = 3'd2;
    localparam logic [PhaseW-1:0] PhWait      = 3'd3;
    localparam logic [PhaseW-1:0] PhBlockDone = 3'd4;
    localparam logic [PhaseW-1:0] PhFinished  = 3'd5;

    // Command kinds carried in s_axis_tuser.
    localparam logic CmdStart = 1'b0;
    localparam logic CmdStep  = 1'b1;

    // Register byte addresses.
    localparam int unsigned PaddrW = 3;
    localparam logic [PaddrW-1:0] RegFastMode    = 3'd0;
    localparam logic [PaddrW-1:0] RegEraseOpcode = 3'd4;

    localparam logic [OpcodeW-1:0] EraseOpcodeReset = 8'd216;

    // Write-in-progress bit of the status byte.
    localparam int unsigned WipBit = 0;

    // Input word as held in the input register.
    typedef struct packed {
        logic                  region_blank;
        logic [StatusW-1:0]    flash_status;
        logic [ByteCountW-1:0] byte_count;
        logic [FlashAddrW-1:0] start_address;
    } in_word_t;

    // Result word as held in the output register.
    typedef struct packed {
        logic                  start_rejected;
        logic                  finished;
        logic [PhaseW-1:0]     state_code;
        logic [FlashAddrW-1:0] erase_address;
        logic [OpcodeW-1:0]    erase_command;
    } out_word_t;

endpackage

`default_nettype wire

/* sv/flash_block_erase_sequencer_core.sv */
`default_nettype none

// A word accepted on s_axis passes through the input register, then the result
// register, before it is presented on m_axis.
// Throughput: one word per cycle while m_axis is not stalled; the phase machine updates once per word.
// Reset: rst_n clears the phase to idle, both addresses to zero, fast_mode to 0,
// erase_opcode to 216, and empties both pipeline registers.
module flash_block_erase_sequencer_core #(
    parameter int unsigned ERASE_BLOCK_BYTES = fbes_pkg::EraseBlockBytesDefault,
    parameter int unsigned ADDRESS_BITS      = fbes_pkg::AddressBitsDefault
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    // APB configuration port.
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [fbes_pkg::PaddrW-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,

    // Input stream.
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: start_address[23:0], byte_count[48:24], flash_status[56:49],
    // region_blank[57], zero fill[63:58].
    input  wire logic [63:0]               s_axis_tdata,
    // tuser: cmd[0].
    input  wire logic                      s_axis_tuser,

    // Result stream.
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // tdata: erase_command[7:0], erase_address[31:8], state_code[34:32],
    // finished[35], start_rejected[36], zero fill[39:37].
    output logic      [39:0]               m_axis_tdata,
    // tuser: issue_erase[0].
    output logic                           m_axis_tuser
);
    import fbes_pkg::*;

    localparam logic [InternAddrW-1:0] BlockStep = InternAddrW'(ERASE_BLOCK_BYTES);
    localparam logic [FlashAddrW-1:0]  AddrMask  =
        FlashAddrW'((64'd1 << ADDRESS_BITS) - 64'd1);

    // Configuration registers.
    logic               fast_mode_reg;
    logic [OpcodeW-1:0] erase_opcode_reg;

    // Pipeline registers.
    logic      in_valid_reg;
    logic      in_cmd_reg;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    logic      out_issue_reg;
    out_word_t out_word_reg;

    // Sequencer state.
    logic [PhaseW-1:0]      phase_reg, phase_next;
    logic [InternAddrW-1:0] cur_addr_reg, cur_addr_next;
    logic [InternAddrW-1:0] end_addr_reg, end_addr_next;

    logic                   advance;
    logic                   issue;
    logic                   rejected;
    logic [InternAddrW-1:0] stepped_addr;
    logic                   block_done;
    logic [PhaseW-1:0]      run_phase;

    // APB register file; writes complete in the access cycle.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_mode_reg    <= 1'b0;
            erase_opcode_reg <= EraseOpcodeReset;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == RegFastMode[2])
                fast_mode_reg <= pwdata[0];
            else
                erase_opcode_reg <= pwdata[OpcodeW-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == RegEraseOpcode[2])
            prdata = {24'd0, erase_opcode_reg};
        else
            prdata = {31'd0, fast_mode_reg};
    end

    // Handshake: the result register frees when taken, the input register when it moves on.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_word_reg <= in_word_t'(s_axis_tdata[57:0]);
        end
    end

    // Phase machine: one update for each word leaving the input register.
    assign stepped_addr = cur_addr_reg + BlockStep;
    assign block_done   = (phase_reg == PhBlockDone) || !in_word_reg.flash_status[WipBit];
    assign run_phase    = fast_mode_reg ? PhBlank : PhErase;

    always_comb
    begin
        phase_next    = phase_reg;
        cur_addr_next = cur_addr_reg;
        end_addr_next = end_addr_reg;
        issue         = 1'b0;
        rejected      = 1'b0;
        if (in_cmd_reg == CmdStart)
        begin
            if (phase_reg == PhIdle || phase_reg == PhFinished)
            begin
                cur_addr_next = {2'b00, in_word_reg.start_address};
                end_addr_next = {2'b00, in_word_reg.start_address}
                              + {1'b0, in_word_reg.byte_count};
                phase_next    = run_phase;
            end
            else
                rejected = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PhBlank:
                    phase_next = in_word_reg.region_blank ? PhBlockDone : PhErase;
                PhErase:
                begin
                    issue      = 1'b1;
                    phase_next = PhWait;
                end
                PhWait, PhBlockDone:
                begin
                    if (block_done)
                    begin
                        cur_addr_next = stepped_addr;
                        phase_next    = (stepped_addr >= end_addr_reg) ? PhFinished
                                                                       : run_phase;
                    end
                end
                default:
                    phase_next = phase_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PhIdle;
            cur_addr_reg <= '0;
            end_addr_reg <= '0;
        end
        else if (advance && in_valid_reg)
        begin
            phase_reg    <= phase_next;
            cur_addr_reg <= cur_addr_next;
            end_addr_reg <= end_addr_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_issue_reg                <= issue;
            out_word_reg.erase_command   <= issue ? erase_opcode_reg : '0;
            out_word_reg.erase_address   <= issue ? (cur_addr_reg[FlashAddrW-1:0] & AddrMask)
                                                  : '0;
            out_word_reg.state_code      <= phase_next;
            out_word_reg.finished        <= (phase_next == PhFinished);
            out_word_reg.start_rejected  <= rejected;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_issue_reg;
    assign m_axis_tdata  = {3'b000, out_word_reg};

endmodule

`default_nettype wire
